>>> rtl/rpcf_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the rolling palette color fader.
// Depends on nothing; imported by every module of the block.
package rpcf_pkg;

    // 5:5:6 color layout
    localparam int COLOR_W   = 16;
    localparam int FIELD_A_W = 5;
    localparam int FIELD_B_W = 5;
    localparam int FIELD_C_W = 6;
    localparam int FIELD_A_LO = 11;
    localparam int FIELD_B_LO = 6;
    localparam int SPEED_W   = 6;
    localparam int MAXC_W    = 6;
    localparam int INDEX_W   = 5;

    // Palette sizing
    localparam int PALETTE_DEPTH_DEF = 32;
    localparam int PALETTE_PORT_SLOTS = 1 << INDEX_W;

    // Timers
    localparam int TIMER_W = 7;
    localparam int DELAY_W = 4;
    localparam logic [TIMER_W-1:0] SLOT_RELOAD      = 7'd120;
    localparam logic [TIMER_W-1:0] SLOT_TIMER_RESET = 7'd90;
    localparam logic [DELAY_W-1:0] FADE_RELOAD      = 4'd3;
    localparam logic [DELAY_W-1:0] FADE_DELAY_RESET = 4'd12;

    // Color reset values
    localparam logic [COLOR_W-1:0] TARGET_RESET  = 16'hF800;
    localparam logic [COLOR_W-1:0] CURRENT_RESET = 16'h0000;

    // Configuration defaults
    localparam logic [SPEED_W-1:0] STEP_SPEED_RESET = 6'd1;
    localparam logic [MAXC_W-1:0]  MAX_COLORS_RESET = 6'd20;

    // Request kinds
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // Register map (selected by paddr bit 2)
    localparam int  CFG_ADDR_W     = 3;
    localparam logic REG_STEP_SPEED = 1'b0;
    localparam logic REG_MAX_COLORS = 1'b1;

endpackage

>>> rtl/rpcf_fade_step.sv
`timescale 1ns / 1ps
// One fade step: each 5:5:6 field of the current color moves toward the target.
// Depends on rpcf_pkg for the color layout.
module rpcf_fade_step
    import rpcf_pkg::*;
(
    input  logic [COLOR_W-1:0] cur_color,
    input  logic [COLOR_W-1:0] tgt_color,
    input  logic [SPEED_W-1:0] speed,
    output logic [COLOR_W-1:0] new_color
);

    // Move src toward dst by speed, stopping at dst
    function automatic logic [SPEED_W-1:0] step_field(
        input logic [SPEED_W-1:0] src,
        input logic [SPEED_W-1:0] dst,
        input logic [SPEED_W-1:0] spd
    );
        logic [SPEED_W-1:0] res;
        res = src;
        if (src < dst)
        begin
            res = ((dst - src) < spd) ? dst : src + spd;
        end
        else if (src > dst)
        begin
            res = ((src - dst) < spd) ? dst : src - spd;
        end
        return res;
    endfunction

    logic [SPEED_W-1:0] a_next;
    logic [SPEED_W-1:0] b_next;
    logic [SPEED_W-1:0] c_next;

    // Step the three fields independently
    always_comb
    begin
        a_next = step_field(SPEED_W'(cur_color[FIELD_A_LO +: FIELD_A_W]),
                            SPEED_W'(tgt_color[FIELD_A_LO +: FIELD_A_W]), speed);
        b_next = step_field(SPEED_W'(cur_color[FIELD_B_LO +: FIELD_B_W]),
                            SPEED_W'(tgt_color[FIELD_B_LO +: FIELD_B_W]), speed);
        c_next = step_field(SPEED_W'(cur_color[0 +: FIELD_C_W]),
                            SPEED_W'(tgt_color[0 +: FIELD_C_W]), speed);
    end

    assign new_color = {a_next[FIELD_A_W-1:0], b_next[FIELD_B_W-1:0], c_next[FIELD_C_W-1:0]};

endmodule

>>> rtl/rolling_palette_color_fader.sv
`timescale 1ns / 1ps
// Top level of the rolling palette color fader: slot timer, palette, fade delay,
// result register with skid stage and APB configuration. Uses rpcf_pkg, rpcf_fade_step.
//
//  channel   handshake                 payload
//  input     in_valid / in_stall       kind, palette_index, palette_color
//  output    out_valid / out_stall     shown_color, color_written
//  config    APB psel/penable/pwrite   paddr[2:0], pwdata, prdata (2 registers)
//
// One request per clock while in_stall is low; each accepted request yields one result.
// The tick update (palette select, field step, counters) is one combinational pass
// from the state registers into the result register.
// rst_n loads the reset values of all block state and clears the palette to zero; no
// clearing pass is needed.
// A skid stage takes a result while the output is stalled; in_stall rises only
// when both the output and the skid register are full.
module rolling_palette_color_fader
    import rpcf_pkg::*;
#(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // request channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  kind,
    input  logic [INDEX_W-1:0]    palette_index,
    input  logic [COLOR_W-1:0]    palette_color,
    // result channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [COLOR_W-1:0]    shown_color,
    output logic                  color_written,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int SLOT_W  = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int CMP_W   = (SLOT_W + 1 > MAXC_W) ? SLOT_W + 1 : MAXC_W;
    localparam int STORE_D = (PALETTE_DEPTH < PALETTE_PORT_SLOTS) ? PALETTE_DEPTH
                                                                 : PALETTE_PORT_SLOTS;

    // Configuration registers
    logic [SPEED_W-1:0] step_speed_reg;
    logic [MAXC_W-1:0]  max_colors_reg;

    // Block state
    logic [COLOR_W-1:0] current_color_reg, current_color_next;
    logic [COLOR_W-1:0] target_color_reg, target_color_next;
    logic [DELAY_W-1:0] fade_delay_reg, fade_delay_next;
    logic [TIMER_W-1:0] slot_timer_reg, slot_timer_next;
    logic [SLOT_W-1:0]  slot_number_reg, slot_number_next;
    logic [COLOR_W-1:0] palette_reg [STORE_D];

    // Result and skid registers
    logic               out_valid_reg;
    logic [COLOR_W-1:0] out_color_reg;
    logic               out_written_reg;
    logic               skid_valid_reg;
    logic [COLOR_W-1:0] skid_color_reg;
    logic               skid_written_reg;

    logic               in_take;
    logic               out_take;
    logic               written_next;
    logic [CMP_W-1:0]   slot_inc;
    logic               slot_wrap;
    logic [COLOR_W-1:0] slot_color;
    logic [COLOR_W-1:0] faded_color;
    logic               cfg_write;

    assign in_take  = in_valid && !in_stall;
    assign out_take = out_valid_reg && !out_stall;
    assign in_stall = skid_valid_reg;

    assign out_valid     = out_valid_reg;
    assign shown_color   = out_color_reg;
    assign color_written = out_written_reg;

    // Configuration access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[2])
            REG_STEP_SPEED: prdata = 32'(step_speed_reg);
            REG_MAX_COLORS: prdata = 32'(max_colors_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_speed_reg <= STEP_SPEED_RESET;
            max_colors_reg <= MAX_COLORS_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_STEP_SPEED: step_speed_reg <= pwdata[SPEED_W-1:0];
                REG_MAX_COLORS: max_colors_reg <= pwdata[MAXC_W-1:0];
                default:        ;
            endcase
        end
    end

    // Advance the slot with wrap at max_colors or the palette depth
    always_comb
    begin
        slot_inc  = CMP_W'(slot_number_reg) + CMP_W'(1);
        slot_wrap = (slot_inc >= CMP_W'(max_colors_reg)) ||
                    (slot_inc >= CMP_W'(PALETTE_DEPTH));
    end

    // Select the palette entry of the new slot; entries past the stored range read zero
    always_comb
    begin
        slot_color = '0;
        for (int i = 0; i < STORE_D; i++)
        begin
            if (slot_number_next == SLOT_W'(i))
            begin
                slot_color = palette_reg[i];
            end
        end
    end

    rpcf_fade_step u_fade_step (
        .cur_color (current_color_reg),
        .tgt_color (target_color_next),
        .speed     (step_speed_reg),
        .new_color (faded_color)
    );

    // Tick update: slot timer first, then fade delay
    always_comb
    begin
        slot_number_next   = slot_number_reg;
        slot_timer_next    = slot_timer_reg;
        target_color_next  = target_color_reg;
        fade_delay_next    = fade_delay_reg;
        current_color_next = current_color_reg;
        written_next       = 1'b0;
        if (kind == KIND_TICK)
        begin
            if (slot_timer_reg != '0)
            begin
                slot_timer_next = slot_timer_reg - TIMER_W'(1);
            end
            else
            begin
                slot_number_next  = slot_wrap ? '0 : slot_inc[SLOT_W-1:0];
                slot_timer_next   = SLOT_RELOAD;
                target_color_next = slot_color;
            end
            if (fade_delay_reg != '0)
            begin
                fade_delay_next = fade_delay_reg - DELAY_W'(1);
            end
            else
            begin
                current_color_next = faded_color;
                fade_delay_next    = FADE_RELOAD;
                written_next       = 1'b1;
            end
        end
    end

    // Hold state; update on an accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_color_reg <= CURRENT_RESET;
            target_color_reg  <= TARGET_RESET;
            fade_delay_reg    <= FADE_DELAY_RESET;
            slot_timer_reg    <= SLOT_TIMER_RESET;
            slot_number_reg   <= '0;
        end
        else if (in_take)
        begin
            current_color_reg <= current_color_next;
            target_color_reg  <= target_color_next;
            fade_delay_reg    <= fade_delay_next;
            slot_timer_reg    <= slot_timer_next;
            slot_number_reg   <= slot_number_next;
        end
    end

    // Store a palette entry on a write request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_D; i++)
            begin
                palette_reg[i] <= '0;
            end
        end
        else if (in_take && kind == KIND_WRITE)
        begin
            for (int i = 0; i < STORE_D; i++)
            begin
                if (palette_index == INDEX_W'(i))
                begin
                    palette_reg[i] <= palette_color;
                end
            end
        end
    end

    // Result register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (out_take)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (in_take)
            begin
                if (out_valid_reg && out_stall)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b1;
                end
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_color_reg   <= skid_color_reg;
                out_written_reg <= skid_written_reg;
            end
        end
        else if (in_take)
        begin
            if (out_valid_reg && out_stall)
            begin
                skid_color_reg   <= current_color_next;
                skid_written_reg <= written_next;
            end
            else
            begin
                out_color_reg   <= current_color_next;
                out_written_reg <= written_next;
            end
        end
    end

endmodule
